// ===== rtl/pctb_pkg.sv =====
package pctb_pkg;

	localparam int LABEL_W   = 10;
	localparam int CONTACT_W = 14;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NEW   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef logic [LABEL_W-1:0]   label_t;
	typedef logic [CONTACT_W-1:0] contact_t;
	typedef logic [STATUS_W-1:0]  status_t;

	// Controller to datapath
	typedef struct packed {
		logic    clr_step;
		logic    load_in;
		logic    rd_b;
		logic    lat_za;
		logic    lat_zb;
		logic    scan_init;
		logic    scan_step;
		logic    wr_a;
		logic    wr_b;
		logic    set_res;
		status_t res_code;
		logic    out_load;
	} pctb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic pair_ok;
		logic hit;
		logic more;
		logic room;
	} pctb_stat_t;

endpackage

// ===== rtl/pctb_datapath.sv =====
module pctb_datapath import pctb_pkg::*; #(
	parameter int NUM_LABELS = 1024,
	parameter int MAX_COORD  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pctb_cmd_t        cmd,
	output pctb_stat_t       stat,
	input  label_t           centre_label,
	input  label_t           neighbour_label,
	input  logic             max_coordination_wr_en,
	input  logic [CFG_W-1:0] max_coordination,
	output status_t          status,
	output contact_t         contact_label,
	output label_t           low_label,
	output label_t           high_label
);

	localparam int IW  = $clog2(NUM_LABELS);
	localparam int CW  = $clog2(MAX_COORD + 1);
	localparam int LAW = $clog2(NUM_LABELS * MAX_COORD);
	localparam int LDEPTH = NUM_LABELS * MAX_COORD;
	localparam int ENTRY_W = LABEL_W + CONTACT_W;

	typedef logic [ENTRY_W-1:0] entry_t;

	logic [CFG_W-1:0] cfg_q;
	label_t           a_q, b_q;
	logic [IW-1:0]    a_idx, b_idx;
	logic [IW-1:0]    clr_idx_q;
	logic [CW-1:0]    za_q, zb_q, slot_q;
	logic             pend_q;
	contact_t         next_q;
	contact_t         next_inc;

	logic [CW-1:0]    cnt_mem [NUM_LABELS];
	logic [CW-1:0]    cnt_rd_q;
	logic             cnt_we;
	logic [IW-1:0]    cnt_waddr, cnt_raddr;
	logic [CW-1:0]    cnt_wdata;

	entry_t           list_mem [LDEPTH];
	entry_t           list_rd_q;
	logic             list_we;
	logic [LAW-1:0]   list_waddr, list_raddr;
	entry_t           list_wdata;

	status_t          res_status_q;
	contact_t         res_label_q;
	label_t           res_lo_q, res_hi_q;
	status_t          out_status_q;
	contact_t         out_label_q;
	label_t           out_lo_q, out_hi_q;

	logic [31:0]      lim;

	assign a_idx = IW'({22'd0, a_q});
	assign b_idx = IW'({22'd0, b_q});

	assign lim = (32'(cfg_q) > 32'(MAX_COORD)) ? 32'(MAX_COORD) : 32'(cfg_q);

	assign stat.clr_last = (clr_idx_q == IW'(NUM_LABELS - 1));
	assign stat.pair_ok  = (a_q != '0) && (b_q != '0) && (a_q != b_q)
		&& (32'(a_q) < 32'(NUM_LABELS)) && (32'(b_q) < 32'(NUM_LABELS));
	assign stat.hit      = pend_q && (list_rd_q[ENTRY_W-1:CONTACT_W] == b_q);
	assign stat.more     = (slot_q < za_q);
	assign stat.room     = (32'(za_q) < lim) && (32'(zb_q) < lim);

	// Skip contact number 0 on wrap
	assign next_inc = (next_q + CONTACT_W'(1) == '0) ? CONTACT_W'(1) : next_q + CONTACT_W'(1);

	always_comb begin
		cnt_we    = cmd.clr_step || cmd.wr_a || cmd.wr_b;
		cnt_waddr = clr_idx_q;
		cnt_wdata = '0;
		if (cmd.wr_a) begin
			cnt_waddr = a_idx;
			cnt_wdata = za_q + CW'(1);
		end else if (cmd.wr_b) begin
			cnt_waddr = b_idx;
			cnt_wdata = zb_q + CW'(1);
		end
		cnt_raddr = cmd.rd_b ? b_idx : a_idx;
	end

	always_comb begin
		list_we    = cmd.wr_a || cmd.wr_b;
		list_raddr = LAW'(32'(a_idx) * 32'(MAX_COORD) + 32'(slot_q));
		if (cmd.wr_b) begin
			list_waddr = LAW'(32'(b_idx) * 32'(MAX_COORD) + 32'(zb_q));
			list_wdata = {a_q, next_q};
		end else begin
			list_waddr = LAW'(32'(a_idx) * 32'(MAX_COORD) + 32'(za_q));
			list_wdata = {b_q, next_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rd_q <= list_mem[list_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= CFG_RESET;
			clr_idx_q <= '0;
			next_q    <= CONTACT_W'(1);
			slot_q    <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (max_coordination_wr_en) begin
				cfg_q <= max_coordination;
			end
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end
			if (cmd.wr_b) begin
				next_q <= next_inc;
			end
			if (cmd.scan_init) begin
				slot_q <= '0;
				pend_q <= 1'b0;
			end else if (cmd.scan_step) begin
				slot_q <= slot_q + CW'(1);
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q <= centre_label;
			b_q <= neighbour_label;
		end
		if (cmd.lat_za) begin
			za_q <= cnt_rd_q;
		end
		if (cmd.lat_zb) begin
			zb_q <= cnt_rd_q;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_label_q  <= '0;
			res_lo_q     <= '0;
			res_hi_q     <= '0;
			if (cmd.res_code == ST_FOUND) begin
				res_label_q <= list_rd_q[CONTACT_W-1:0];
			end else if (cmd.res_code == ST_NEW) begin
				res_label_q <= next_q;
				res_lo_q    <= (a_q < b_q) ? a_q : b_q;
				res_hi_q    <= (a_q < b_q) ? b_q : a_q;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_label_q  <= res_label_q;
			out_lo_q     <= res_lo_q;
			out_hi_q     <= res_hi_q;
		end
	end

	assign status        = out_status_q;
	assign contact_label = out_label_q;
	assign low_label     = out_lo_q;
	assign high_label    = out_hi_q;

endmodule

// ===== rtl/pctb_ctrl.sv =====
module pctb_ctrl import pctb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pctb_stat_t stat,
	output pctb_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDA   = 4'd2;
	localparam logic [3:0] S_RDB   = 4'd3;
	localparam logic [3:0] S_ZB    = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_ALLOC = 4'd6;
	localparam logic [3:0] S_WRB   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_code = ST_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_RDA;
				end
			end
			S_RDA: begin
				// Drop background, self and out-of-table pairs at once
				if (!stat.pair_ok) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NONE;
					state_d      = S_DONE;
				end else begin
					state_d = S_RDB;
				end
			end
			S_RDB: begin
				cmd.lat_za = 1'b1;
				cmd.rd_b   = 1'b1;
				state_d    = S_ZB;
			end
			S_ZB: begin
				cmd.lat_zb    = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				// Compare the slot read last cycle while reading the next one
				if (stat.hit) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_FOUND;
					state_d      = S_DONE;
				end else if (stat.more) begin
					cmd.scan_step = 1'b1;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (stat.room) begin
					cmd.wr_a = 1'b1;
					state_d  = S_WRB;
				end else begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_FULL;
					state_d      = S_DONE;
				end
			end
			S_WRB: begin
				cmd.wr_b     = 1'b1;
				cmd.set_res  = 1'b1;
				cmd.res_code = ST_NEW;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/particle_contact_table_builder.sv =====
// Channel   Handshake                 Payload
// in        in_valid / in_ready       centre_label, neighbour_label
// out       out_valid / out_ready     status, contact_label, low_label, high_label
// config    max_coordination_wr_en    max_coordination
//
// One request at a time. A background, self or out-of-table pair ends without a
// scan. Other pairs scan the centre list until a hit or until filled slots are
// read, where filled is the centre particle's count; with no hit the pair is then
// refused, if either list is full, or added as a new contact. The single read port
// of the contact list reads one slot a cycle.
// After reset a clearing pass over all NUM_LABELS entries zeroes the counts;
// in_ready stays low meanwhile. The result register frees the input side; a result
// stalled at the output holds only the next one behind it.
module particle_contact_table_builder import pctb_pkg::*; #(
	parameter int NUM_LABELS = 1024,
	parameter int MAX_COORD  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  label_t           centre_label,
	input  label_t           neighbour_label,
	output logic             out_valid,
	input  logic             out_ready,
	output status_t          status,
	output contact_t         contact_label,
	output label_t           low_label,
	output label_t           high_label,
	input  logic             max_coordination_wr_en,
	input  logic [CFG_W-1:0] max_coordination
);

	pctb_cmd_t  cmd;
	pctb_stat_t stat;

	pctb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pctb_datapath #(
		.NUM_LABELS (NUM_LABELS),
		.MAX_COORD  (MAX_COORD)
	) u_datapath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.stat                   (stat),
		.centre_label           (centre_label),
		.neighbour_label        (neighbour_label),
		.max_coordination_wr_en (max_coordination_wr_en),
		.max_coordination       (max_coordination),
		.status                 (status),
		.contact_label          (contact_label),
		.low_label              (low_label),
		.high_label             (high_label)
	);

endmodule
